@@ rtl/psi_section_header_parser_defines.svh @@
// Assertion macros shared by the section header parser RTL.
// No dependencies; files that check themselves include this header.
`ifndef PSI_SECTION_HEADER_PARSER_DEFINES_SVH
`define PSI_SECTION_HEADER_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSP_ASSERT(lbl, prop, msg)
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/psp_pkg.sv @@
// Types and constants for the PSI section header parser.
// No dependencies; used by psp_out_fifo and psi_section_header_parser.
package psp_pkg;

  localparam int MAX_BUFFER_BYTES_DEF = 65536;
  localparam int OUT_DEPTH = 4;

  localparam logic [7:0]  STUFF_BYTE = 8'hFF;
  localparam logic [12:0] HDR_BYTES  = 13'd8;
  localparam logic [11:0] MIN_LENGTH = 12'd5;
  localparam logic [12:0] LENGTH_ADJ = 13'd3;

  typedef enum logic [2:0] {
    MODE_FIRST = 3'd0,
    MODE_HDR   = 3'd1,
    MODE_BODY  = 3'd2,
    MODE_NEXT  = 3'd3,
    MODE_STUFF = 3'd4,
    MODE_ERR   = 3'd5
  } psp_mode_t;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_OK     = 2'd1,
    KIND_SHORT  = 2'd2,
    KIND_LENGTH = 2'd3
  } psp_kind_t;

  typedef struct packed {
    psp_kind_t   kind;
    logic [7:0]  tid;
    logic        syntax_indicator;
    logic        private_indicator;
    logic [11:0] sect_len;
    logic [15:0] tid_ext;
    logic [4:0]  ver_num;
    logic        current_next;
    logic [7:0]  sect_num;
    logic [7:0]  last_sect_num;
    logic [15:0] start_offset;
    logic        last_result;
  } psp_result_t;

endpackage

@@ rtl/psp_out_fifo.sv @@
// Four-entry result queue taking up to two beats per cycle, one out.
// Depends on psp_pkg and psi_section_header_parser_defines.svh.
`include "psi_section_header_parser_defines.svh"

module psp_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_cnt,
  input  psp_pkg::psp_result_t push_d0,
  input  psp_pkg::psp_result_t push_d1,
  output logic                has_space,
  output logic                out_valid,
  input  logic                out_ready,
  output psp_pkg::psp_result_t out_data
);
  import psp_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  psp_result_t mem_r [OUT_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign has_space = (count_r <= CW'(OUT_DEPTH - 2));
  assign out_data  = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + PW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_d1;
    end
  end

  `PSP_ASSERT(a_count_bound, count_r <= CW'(OUT_DEPTH), "result queue overfilled")
  `PSP_ASSERT(a_push_room, (push_cnt == 2'd0) || has_space, "push without room")
  `PSP_ASSERT_NEXT(a_stay_empty, (count_r == '0) && (push_cnt == 2'd0), !out_valid,
                   "empty queue produced a beat")

endmodule

@@ rtl/psi_section_header_parser.sv @@
// MPEG-2 long-form private section header parser, one byte per beat.
// Depends on psp_pkg, psp_out_fifo and psi_section_header_parser_defines.svh.
//
// Bytes are taken one per cycle while ready; each byte is parsed in the cycle it is
// accepted and its results (a section record and/or the end-of-buffer status,
// at most two) land in a four-entry result queue, visible the next cycle.
// in_ready drops only while that queue holds more than two results, so with
// out_ready high the sustained rate is one byte per clock. After the status
// beat of a buffer the parser is back in its reset state for the next one.
`include "psi_section_header_parser_defines.svh"

module psi_section_header_parser #(
  parameter int MAX_BUFFER_BYTES = psp_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_tid,
  output logic        out_syntax_indicator,
  output logic        out_private_indicator,
  output logic [11:0] out_sect_len,
  output logic [15:0] out_tid_ext,
  output logic [4:0]  out_ver_num,
  output logic        out_current_next,
  output logic [7:0]  out_sect_num,
  output logic [7:0]  out_last_sect_num,
  output logic [15:0] out_start_offset,
  output logic        out_last_result
);
  import psp_pkg::*;

  localparam int CEIL_INT = (MAX_BUFFER_BYTES - 1 > 65535) ? 65535 : MAX_BUFFER_BYTES - 1;
  localparam logic [15:0] OFFSET_CEIL = 16'(CEIL_INT);

  psp_mode_t   mode_r, mode_nxt;
  logic [12:0] bis_r, bis_nxt;
  logic [11:0] len_r, len_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [15:0] start_r, start_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        in_fire;
  logic        rec_push;
  logic [63:0] hdr_shift;
  logic [63:0] hdr_rec;
  logic [11:0] hdr_len;
  psp_kind_t   status_kind;
  psp_result_t rec, status, d0, d1, q;
  logic [1:0]  push_cnt;
  logic        has_space;

  assign in_ready  = has_space;
  assign in_fire   = in_valid && in_ready;
  assign hdr_shift = {hdr_r[55:0], in_data_byte};
  assign hdr_len   = {hdr_shift[51:48], hdr_shift[47:40]};

  always_comb begin
    mode_nxt    = mode_r;
    bis_nxt     = bis_r;
    len_nxt     = len_r;
    hdr_nxt     = hdr_r;
    offset_nxt  = offset_r;
    start_nxt   = start_r;
    err_nxt     = err_r;
    rec_push    = 1'b0;
    status_kind = KIND_OK;

    case (mode_r)
      MODE_FIRST, MODE_NEXT: begin
        if ((mode_r == MODE_NEXT) && (in_data_byte == STUFF_BYTE)) begin
          mode_nxt = MODE_STUFF;
        end else begin
          start_nxt = offset_r;
          hdr_nxt   = {56'd0, in_data_byte};
          bis_nxt   = 13'd1;
          mode_nxt  = MODE_HDR;
        end
      end
      MODE_HDR: begin
        hdr_nxt = hdr_shift;
        bis_nxt = bis_r + 13'd1;
        if (bis_nxt >= HDR_BYTES) begin
          len_nxt = hdr_len;
          if (hdr_len < MIN_LENGTH) begin
            err_nxt  = KIND_LENGTH;
            mode_nxt = MODE_ERR;
          end else if (hdr_len == MIN_LENGTH) begin
            rec_push = 1'b1;
            mode_nxt = MODE_NEXT;
          end else begin
            mode_nxt = MODE_BODY;
          end
        end
      end
      MODE_BODY: begin
        bis_nxt = bis_r + 13'd1;
        if (bis_nxt >= {1'b0, len_r} + LENGTH_ADJ) begin
          rec_push = 1'b1;
          mode_nxt = MODE_NEXT;
        end
      end
      default: begin
      end
    endcase

    if (offset_r < OFFSET_CEIL) begin
      offset_nxt = offset_r + 16'd1;
    end

    case (mode_nxt)
      MODE_ERR:  status_kind = psp_kind_t'(err_nxt);
      MODE_HDR:  status_kind = KIND_SHORT;
      MODE_BODY: status_kind = KIND_LENGTH;
      default:   status_kind = KIND_OK;
    endcase

    if (in_last_byte) begin
      mode_nxt   = MODE_FIRST;
      bis_nxt    = '0;
      len_nxt    = '0;
      hdr_nxt    = '0;
      offset_nxt = '0;
      start_nxt  = '0;
      err_nxt    = '0;
    end
  end

  // header with this byte in, taken before the end-of-buffer clear
  assign hdr_rec = (mode_r == MODE_HDR) ? hdr_shift : hdr_r;

  always_comb begin
    rec                   = '0;
    rec.kind              = KIND_RECORD;
    rec.tid               = hdr_rec[63:56];
    rec.syntax_indicator  = hdr_rec[55];
    rec.private_indicator = hdr_rec[54];
    rec.sect_len          = {hdr_rec[51:48], hdr_rec[47:40]};
    rec.tid_ext           = hdr_rec[39:24];
    rec.ver_num           = hdr_rec[21:17];
    rec.current_next      = hdr_rec[16];
    rec.sect_num          = hdr_rec[15:8];
    rec.last_sect_num     = hdr_rec[7:0];
    rec.start_offset      = start_r;
    rec.last_result       = 1'b0;
  end

  always_comb begin
    status             = '0;
    status.kind        = status_kind;
    status.last_result = 1'b1;
    d0       = rec;
    d1       = status;
    push_cnt = 2'd0;
    if (in_fire) begin
      if (rec_push && in_last_byte) begin
        push_cnt = 2'd2;
      end else if (rec_push) begin
        push_cnt = 2'd1;
      end else if (in_last_byte) begin
        push_cnt = 2'd1;
        d0       = status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_FIRST;
      bis_r    <= '0;
      len_r    <= '0;
      hdr_r    <= '0;
      offset_r <= '0;
      start_r  <= '0;
      err_r    <= '0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      bis_r    <= bis_nxt;
      len_r    <= len_nxt;
      hdr_r    <= hdr_nxt;
      offset_r <= offset_nxt;
      start_r  <= start_nxt;
      err_r    <= err_nxt;
    end
  end

  psp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_d0   (d0),
    .push_d1   (d1),
    .has_space (has_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q)
  );

  assign out_result_kind       = q.kind;
  assign out_tid               = q.tid;
  assign out_syntax_indicator  = q.syntax_indicator;
  assign out_private_indicator = q.private_indicator;
  assign out_sect_len          = q.sect_len;
  assign out_tid_ext           = q.tid_ext;
  assign out_ver_num           = q.ver_num;
  assign out_current_next      = q.current_next;
  assign out_sect_num          = q.sect_num;
  assign out_last_result       = q.last_result;
  assign out_last_sect_num     = q.last_sect_num;
  assign out_start_offset      = q.start_offset;

  `PSP_ASSERT(a_status_clean, !(out_valid && out_last_result) ||
              ((out_result_kind != KIND_RECORD) && (out_start_offset == 16'd0) &&
               (out_sect_len == 12'd0)), "status beat carries header data")
  `PSP_ASSERT_NEXT(a_buffer_reset, in_fire && in_last_byte,
                   (mode_r == MODE_FIRST) && (offset_r == 16'd0),
                   "parser not reset after buffer end")
  `PSP_ASSERT_NEXT(a_stuff_holds, in_fire && (mode_r == MODE_STUFF) && !in_last_byte,
                   mode_r == MODE_STUFF, "left stuffing before buffer end")

endmodule
